// ===== design/cce_pkg.sv =====
package cce_pkg;

  localparam int unsigned MAX_OUT = 6;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QAW     = 2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_OCT   = 8'h08;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;

  // one queued command: the escaped bytes of one input transaction
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] seq;
    logic [CNT_W-1:0]        cnt;
    logic                    last;
  } cmd_t;

  function automatic logic [7:0] letter_for(logic [7:0] c);
    logic [7:0] l;
    case (c)
      8'h07:   l = 8'h61;
      8'h08:   l = 8'h62;
      8'h1B:   l = 8'h65;
      8'h0C:   l = 8'h66;
      8'h0D:   l = 8'h72;
      8'h09:   l = 8'h74;
      8'h0B:   l = 8'h76;
      default: l = 8'h00;
    endcase
    return l;
  endfunction

endpackage

// ===== design/cce_if.sv =====
interface cce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface cce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== design/cce_front.sv =====
module cce_front (
  input  logic          clk,
  input  logic          rst_n,
  cce_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output cce_pkg::cmd_t cmd
);

  logic                          held_r;
  logic                          held_nxt;
  logic                          take;
  logic [7:0]                    c;
  logic                          eos;
  logic [7:0]                    lt;
  logic [3:0][7:0]               b;
  logic [cce_pkg::CNT_W-1:0]     bn;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign c           = in_ch.data_byte;
  assign eos         = in_ch.end_of_string;
  assign lt          = cce_pkg::letter_for(c);

  // escape of the current byte alone
  always_comb begin
    b  = '0;
    bn = 3'd1;
    if (c >= cce_pkg::CH_SPACE) begin
      b[0] = c;
      bn   = 3'd1;
    end else if (lt != 8'h00) begin
      b[0] = cce_pkg::CH_BSL;
      b[1] = lt;
      bn   = 3'd2;
    end else begin
      b[0] = cce_pkg::CH_BSL;
      b[1] = cce_pkg::CH_ZERO;
      if (c >= cce_pkg::CH_OCT) begin
        b[2] = cce_pkg::CH_ZERO + {5'b0, c[5:3]};
        b[3] = cce_pkg::CH_ZERO + {5'b0, c[2:0]};
        bn   = 3'd4;
      end else begin
        b[2] = cce_pkg::CH_ZERO + {5'b0, c[2:0]};
        bn   = 3'd3;
      end
    end
  end

  always_comb begin
    held_nxt = held_r;
    push     = 1'b0;
    cmd      = '0;
    if (take) begin
      if (held_r && c == cce_pkg::CH_LF) begin
        held_nxt   = 1'b0;
        cmd.seq[0] = cce_pkg::CH_BSL;
        cmd.seq[1] = cce_pkg::CH_N;
        cmd.cnt    = 3'd2;
        cmd.last   = eos;
        push       = 1'b1;
      end else if (c == cce_pkg::CH_CR && !eos) begin
        held_nxt   = 1'b1;
        cmd.seq[0] = cce_pkg::CH_BSL;
        cmd.seq[1] = cce_pkg::CH_R;
        cmd.cnt    = 3'd2;
        cmd.last   = 1'b0;
        push       = held_r;
      end else begin
        held_nxt = 1'b0;
        if (held_r) begin
          cmd.seq[0] = cce_pkg::CH_BSL;
          cmd.seq[1] = cce_pkg::CH_R;
          cmd.seq[2] = b[0];
          cmd.seq[3] = b[1];
          cmd.seq[4] = b[2];
          cmd.seq[5] = b[3];
          cmd.cnt    = bn + 3'd2;
        end else begin
          cmd.seq[0] = b[0];
          cmd.seq[1] = b[1];
          cmd.seq[2] = b[2];
          cmd.seq[3] = b[3];
          cmd.cnt    = bn;
        end
        cmd.last = eos;
        push     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
    end
  end

endmodule

// ===== design/cce_queue.sv =====
module cce_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cce_pkg::cmd_t din,
  input  logic          pop,
  output cce_pkg::cmd_t dout,
  output logic          full,
  output logic          empty
);

  cce_pkg::cmd_t                 mem [cce_pkg::QDEPTH];
  logic [cce_pkg::QAW-1:0]       wp_r;
  logic [cce_pkg::QAW-1:0]       wp_nxt;
  logic [cce_pkg::QAW-1:0]       rp_r;
  logic [cce_pkg::QAW-1:0]       rp_nxt;
  logic [cce_pkg::QAW:0]         cnt_r;
  logic [cce_pkg::QAW:0]         cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign full    = cnt_r == (cce_pkg::QAW + 1)'(cce_pkg::QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/cce_back.sv =====
module cce_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cce_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          pop,
  cce_out_if.source     out_ch
);

  logic [cce_pkg::CNT_W-1:0] idx_r;
  logic [cce_pkg::CNT_W-1:0] idx_nxt;
  logic                      vld_r;
  logic                      vld_nxt;
  logic [7:0]                byte_r;
  logic [7:0]                byte_nxt;
  logic                      last_r;
  logic                      last_nxt;
  logic                      load;
  logic                      fin;

  assign load = !q_empty && (!vld_r || out_ch.ready);
  assign fin  = idx_r == head.cnt - 3'd1;
  assign pop  = load && fin;

  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    if (load) begin
      vld_nxt  = 1'b1;
      byte_nxt = head.seq[idx_r];
      last_nxt = head.last && fin;
      idx_nxt  = fin ? '0 : idx_r + 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign out_ch.valid    = vld_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.out_last = last_r;

endmodule

// ===== design/control_char_escape_encoder.sv =====
// Escapes a byte string into printable text, one output byte per cycle while the output
// is ready. Bytes from 0x20 up pass unchanged; named control bytes become a backslash and
// a letter, other control bytes a backslash and octal digits, and CR LF becomes
// backslash n. A CR that does not end the string is held and produces output only when
// the next byte arrives. The front end turns each input transaction into a command of up
// to six bytes and queues it (four deep); the back end drains the head command through an
// output register at one byte per cycle while the output is ready. An input byte
// therefore yields zero to six output bytes (at most four for a byte that follows no held
// CR, none for a held CR); input is taken back to back while the queue has room.
module control_char_escape_encoder (
  input  logic       clk,
  input  logic       rst_n,
  cce_in_if.sink     in_ch,
  cce_out_if.source  out_ch
);

  cce_pkg::cmd_t cmd_in;
  cce_pkg::cmd_t cmd_head;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  cce_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (cmd_in)
  );

  cce_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (cmd_in),
    .pop   (pop),
    .dout  (cmd_head),
    .full  (q_full),
    .empty (q_empty)
  );

  cce_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (cmd_head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
